FILE: hw/rtl/dtoi_pkg.sv
// Package with the request and result types of the double-to-integer converter.
`timescale 1ns / 1ps
package dtoi_pkg;

  typedef enum logic [1:0] {
    WIDTH_16 = 2'd0,
    WIDTH_32 = 2'd1,
    WIDTH_64 = 2'd2
  } width_e;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam int unsigned EXP_BIAS_INT = 1075;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [1:0]  width_select;
  } req_t;

  typedef struct packed {
    logic signed [63:0] int_result;
    logic               out_of_range;
  } rsp_t;

  // Decoded operand after the first stage.
  typedef struct packed {
    logic        neg;
    logic        is_nan_inf;
    logic        huge;
    logic        left;       // exponent at or above the integer point
    logic [5:0]  shamt;      // left shift amount, or right shift amount
    logic        zero_out;   // right shift of 54 or more
    logic [52:0] mant;
    logic [1:0]  wsel;
  } dec_t;

  // Shifted magnitude before rounding.
  typedef struct packed {
    logic        neg;
    logic        bad;
    logic [63:0] q;
    logic        round_up;
    logic [1:0]  wsel;
  } shf_t;

endpackage

FILE: hw/rtl/dtoi_decode.sv
// First stage: field split and exponent decode.
`timescale 1ns / 1ps
module dtoi_decode (
  input  dtoi_pkg::req_t req_i,
  output dtoi_pkg::dec_t dec_o
);
  logic [10:0] expf;
  logic [11:0] e;
  logic signed [12:0] k;

  always_comb begin
    expf = req_i.value_bits[62:52];
    e = (expf != 11'd0) ? {1'b0, expf} : 12'd1;
    k = $signed({1'b0, e}) - 13'sd1075;
    dec_o.neg = req_i.value_bits[63];
    dec_o.is_nan_inf = (expf == dtoi_pkg::EXP_ALL_ONES);
    dec_o.huge = (k >= 13'sd12);
    dec_o.left = (k >= 13'sd0);
    dec_o.zero_out = (k <= -13'sd54);
    dec_o.shamt = (k >= 13'sd0) ? k[5:0] : 6'((-k) & 13'sd63);
    dec_o.mant = {(expf != 11'd0), req_i.value_bits[51:0]};
    dec_o.wsel = req_i.width_select;
  end
endmodule

FILE: hw/rtl/dtoi_shift.sv
// Second stage: alignment shift and rounding decision.
`timescale 1ns / 1ps
module dtoi_shift (
  input  dtoi_pkg::dec_t dec_i,
  output dtoi_pkg::shf_t shf_o
);
  logic [116:0] ext;
  logic [116:0] sh;
  logic         half_bit;
  logic         sticky;

  always_comb begin
    ext = {64'd0, dec_i.mant};
    sh = ext << (dec_i.left ? 7'(dec_i.shamt) : 7'd0);
    // Right shift keeps the dropped bits in a low extension for rounding.
    half_bit = 1'b0;
    sticky = 1'b0;
    shf_o.q = sh[63:0];
    if (!dec_i.left) begin
      sh = {dec_i.mant, 64'd0} >> dec_i.shamt;
      shf_o.q = {11'd0, sh[116:64]};
      half_bit = sh[63];
      sticky = |sh[62:0];
      if (dec_i.zero_out) begin
        shf_o.q = '0;
        half_bit = 1'b0;
      end
    end
    shf_o.round_up = half_bit && (sticky || shf_o.q[0]);
    shf_o.neg = dec_i.neg;
    shf_o.bad = dec_i.is_nan_inf || dec_i.huge;
    shf_o.wsel = dec_i.wsel;
  end
endmodule

FILE: hw/rtl/dtoi_range.sv
// Third stage: rounding increment, range check and sign application.
`timescale 1ns / 1ps
module dtoi_range (
  input  dtoi_pkg::shf_t shf_i,
  output dtoi_pkg::rsp_t rsp_o
);
  logic [64:0] mag;
  logic [63:0] lim_neg;
  logic        bad;

  always_comb begin
    mag = {1'b0, shf_i.q} + {64'd0, shf_i.round_up};
    unique case (shf_i.wsel)
      dtoi_pkg::WIDTH_16: lim_neg = 64'h8000;
      dtoi_pkg::WIDTH_32: lim_neg = 64'h8000_0000;
      default:            lim_neg = 64'h8000_0000_0000_0000;
    endcase
    bad = shf_i.bad || mag[64] ||
          (shf_i.neg ? (mag[63:0] > lim_neg) : (mag[63:0] > lim_neg - 64'd1));
    rsp_o.out_of_range = bad;
    rsp_o.int_result = bad ? $signed(64'd0 - lim_neg)
                           : (shf_i.neg ? $signed(64'd0 - mag[63:0]) : $signed(mag[63:0]));
  end
endmodule

FILE: hw/rtl/double_to_int_store_convert_top.sv
// Top level of the pipelined binary64 to integer converter.
`timescale 1ns / 1ps
// Converts a binary64 pattern to a 16, 32 or 64 bit signed integer, rounding to
// nearest even, sign-extended to 64 bits; NaN, infinity and out-of-range values
// give the most negative value of the width and set out_of_range. One request
// enters per cycle unless the output stalls; each result passes through three
// register stages (decode, align shift, round and range check). A finished
// result held by a stall on the output freezes the whole pipeline and the input.
module double_to_int_store_convert_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dtoi_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dtoi_pkg::rsp_t out_data_o
);
  dtoi_pkg::dec_t dec_d, dec_q;
  dtoi_pkg::shf_t shf_d, shf_q;
  dtoi_pkg::rsp_t rsp_d, rsp_q;
  logic v1_q, v2_q, v3_q;
  logic adv;

  // The pipeline moves whenever the last stage is empty or its result leaves.
  assign adv = !(v3_q && out_stall_i);
  assign in_stall_o = !adv;

  dtoi_decode u_dec (.req_i(in_data_i), .dec_o(dec_d));
  dtoi_shift  u_shf (.dec_i(dec_q), .shf_o(shf_d));
  dtoi_range  u_rng (.shf_i(shf_q), .rsp_o(rsp_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_q <= dec_d;
      shf_q <= shf_d;
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o = rsp_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted request lost");
endmodule
